// File: design/ssse3alu_pkg.sv
package ssse3alu_pkg;

    localparam int VEC_W     = 128;
    localparam int HALF_W    = 64;
    localparam int CMD_W     = 4;
    localparam int IMM_W     = 8;
    localparam int ALIGN_MAX = 31;

    typedef enum logic [CMD_W-1:0] {
        CMD_ABS_B     = 4'd0,
        CMD_ABS_W     = 4'd1,
        CMD_ABS_D     = 4'd2,
        CMD_ALIGN     = 4'd3,
        CMD_HADD_W    = 4'd4,
        CMD_HADD_D    = 4'd5,
        CMD_HADDS_W   = 4'd6,
        CMD_HSUB_W    = 4'd7,
        CMD_HSUB_D    = 4'd8,
        CMD_HSUBS_W   = 4'd9,
        CMD_MADDUBS   = 4'd10,
        CMD_MULHRS    = 4'd11,
        CMD_SHUFFLE   = 4'd12,
        CMD_SIGN_B    = 4'd13,
        CMD_SIGN_W    = 4'd14,
        CMD_SIGN_D    = 4'd15
    } t_cmd;

    // Clamps a signed value to the signed 16-bit range.
    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7fff;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: design/ssse3alu_if.sv
interface ssse3alu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [63:0] dest_low;
    logic [63:0] dest_high;
    logic [63:0] src_low;
    logic [63:0] src_high;
    logic [7:0]  shift_imm;

    modport source (
        output valid, cmd, dest_low, dest_high, src_low, src_high, shift_imm,
        input  ready
    );
    modport sink (
        input  valid, cmd, dest_low, dest_high, src_low, src_high, shift_imm,
        output ready
    );
endinterface

interface ssse3alu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;

    modport source (
        output valid, result_low, result_high,
        input  ready
    );
    modport sink (
        input  valid, result_low, result_high,
        output ready
    );
endinterface

// File: design/ssse3alu_core.sv
module ssse3alu_core
    import ssse3alu_pkg::*;
(
    input  t_cmd             i_cmd,
    input  logic [VEC_W-1:0] i_dest,
    input  logic [VEC_W-1:0] i_src,
    input  logic [IMM_W-1:0] i_shift_imm,
    output logic [VEC_W-1:0] o_result
);

    logic [VEC_W-1:0]   abs_b, abs_w, abs_d;
    logic [VEC_W-1:0]   sgn_b, sgn_w, sgn_d;
    logic [VEC_W-1:0]   hadd_w, hadds_w, hsub_w, hsubs_w, hadd_d, hsub_d;
    logic [VEC_W-1:0]   madd, mulhrs, shuf, align;
    logic [2*VEC_W-1:0] pair_src;
    logic [2*VEC_W-1:0] align_cat;
    logic [2*VEC_W-1:0] align_sh;
    logic signed [16:0] hw_sum [8];
    logic signed [16:0] hw_dif [8];
    logic signed [16:0] mp0 [8];
    logic signed [16:0] mp1 [8];
    logic signed [31:0] mh [8];
    logic [17:0]        mh_rnd [8];

    // The horizontal ops pair neighboring elements of the source above the destination.
    assign pair_src  = {i_src, i_dest};
    assign align_cat = {i_dest, i_src};
    assign align_sh  = align_cat >> {i_shift_imm[4:0], 3'b000};
    assign align     = (i_shift_imm > IMM_W'(ALIGN_MAX)) ? '0 : align_sh[VEC_W-1:0];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            abs_b[8*i +: 8] = i_src[8*i+7] ? (~i_src[8*i +: 8] + 8'd1) : i_src[8*i +: 8];
            if (i_src[8*i+7]) begin
                sgn_b[8*i +: 8] = ~i_dest[8*i +: 8] + 8'd1;
            end else if (i_src[8*i +: 8] == 8'd0) begin
                sgn_b[8*i +: 8] = 8'd0;
            end else begin
                sgn_b[8*i +: 8] = i_dest[8*i +: 8];
            end
            shuf[8*i +: 8] = i_src[8*i+7] ? 8'd0 : i_dest[{i_src[8*i +: 4], 3'b000} +: 8];
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            abs_w[16*i +: 16] = i_src[16*i+15] ? (~i_src[16*i +: 16] + 16'd1)
                                               : i_src[16*i +: 16];
            if (i_src[16*i+15]) begin
                sgn_w[16*i +: 16] = ~i_dest[16*i +: 16] + 16'd1;
            end else if (i_src[16*i +: 16] == 16'd0) begin
                sgn_w[16*i +: 16] = 16'd0;
            end else begin
                sgn_w[16*i +: 16] = i_dest[16*i +: 16];
            end

            hw_sum[i] = $signed({pair_src[32*i+15], pair_src[32*i +: 16]})
                      + $signed({pair_src[32*i+31], pair_src[32*i+16 +: 16]});
            hw_dif[i] = $signed({pair_src[32*i+15], pair_src[32*i +: 16]})
                      - $signed({pair_src[32*i+31], pair_src[32*i+16 +: 16]});
            hadd_w[16*i +: 16]  = hw_sum[i][15:0];
            hsub_w[16*i +: 16]  = hw_dif[i][15:0];
            hadds_w[16*i +: 16] = sat16({hw_sum[i][16], hw_sum[i]});
            hsubs_w[16*i +: 16] = sat16({hw_dif[i][16], hw_dif[i]});

            mp0[i] = $signed({1'b0, i_dest[16*i +: 8]}) * $signed(i_src[16*i +: 8]);
            mp1[i] = $signed({1'b0, i_dest[16*i+8 +: 8]}) * $signed(i_src[16*i+8 +: 8]);
            madd[16*i +: 16] = sat16($signed({mp0[i][16], mp0[i]})
                                   + $signed({mp1[i][16], mp1[i]}));

            mh[i] = $signed(i_dest[16*i +: 16]) * $signed(i_src[16*i +: 16]);
            mh_rnd[i] = mh[i][31:14] + 18'd1;
            mulhrs[16*i +: 16] = mh_rnd[i][16:1];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            abs_d[32*i +: 32] = i_src[32*i+31] ? (~i_src[32*i +: 32] + 32'd1)
                                               : i_src[32*i +: 32];
            if (i_src[32*i+31]) begin
                sgn_d[32*i +: 32] = ~i_dest[32*i +: 32] + 32'd1;
            end else if (i_src[32*i +: 32] == 32'd0) begin
                sgn_d[32*i +: 32] = 32'd0;
            end else begin
                sgn_d[32*i +: 32] = i_dest[32*i +: 32];
            end
            hadd_d[32*i +: 32] = pair_src[64*i +: 32] + pair_src[64*i+32 +: 32];
            hsub_d[32*i +: 32] = pair_src[64*i +: 32] - pair_src[64*i+32 +: 32];
        end
    end

    always_comb begin
        case (i_cmd)
            CMD_ABS_B:   o_result = abs_b;
            CMD_ABS_W:   o_result = abs_w;
            CMD_ABS_D:   o_result = abs_d;
            CMD_ALIGN:   o_result = align;
            CMD_HADD_W:  o_result = hadd_w;
            CMD_HADD_D:  o_result = hadd_d;
            CMD_HADDS_W: o_result = hadds_w;
            CMD_HSUB_W:  o_result = hsub_w;
            CMD_HSUB_D:  o_result = hsub_d;
            CMD_HSUBS_W: o_result = hsubs_w;
            CMD_MADDUBS: o_result = madd;
            CMD_MULHRS:  o_result = mulhrs;
            CMD_SHUFFLE: o_result = shuf;
            CMD_SIGN_B:  o_result = sgn_b;
            CMD_SIGN_W:  o_result = sgn_w;
            CMD_SIGN_D:  o_result = sgn_d;
            default:     o_result = '0;
        endcase
    end

endmodule

// File: design/ssse3_packed_integer_alu_top.sv
// Packed integer vector unit for the SSSE3 operation set.
// An operation item enters on i_req: a command, a 128-bit destination and
// source vector given as low and high halves, and a byte count used only by
// the align command. Each item gives exactly one result item on o_rsp, the
// 128-bit result as low and high halves. Items are taken when valid and
// ready are both high on a rising edge of i_clk.
// The unit has an input register and a result register with all lane
// arithmetic between them. An accepted item moves from the input register to
// the result register and is offered on o_rsp. While o_rsp.ready stays high a
// new item can be accepted at every edge, so the sustained rate is one item per cycle.
// When the receiver holds o_rsp.ready low, the result stays on o_rsp and one
// more item can still be taken into the input register; after that i_req.ready
// drops until the result is taken. Reset (i_rst_n low, synchronous) empties
// both registers. No state is kept from one item to the next.
module ssse3_packed_integer_alu_top
    import ssse3alu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssse3alu_in_if.sink           i_req,
    ssse3alu_out_if.source        o_rsp
);

    logic             r_in_vld;
    logic [CMD_W-1:0] r_cmd;
    logic [VEC_W-1:0] r_dest;
    logic [VEC_W-1:0] r_src;
    logic [IMM_W-1:0] r_imm;
    logic             r_out_vld;
    logic [VEC_W-1:0] r_res;
    logic [VEC_W-1:0] n_res;
    logic             out_adv;
    logic             in_rdy;

    assign out_adv     = !r_out_vld || o_rsp.ready;
    assign in_rdy      = !r_in_vld || out_adv;
    assign i_req.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_in_vld <= i_req.valid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_rdy) begin
            r_cmd  <= i_req.cmd;
            r_dest <= {i_req.dest_high, i_req.dest_low};
            r_src  <= {i_req.src_high, i_req.src_low};
            r_imm  <= i_req.shift_imm;
        end
        if (r_in_vld && out_adv) begin
            r_res <= n_res;
        end
    end

    ssse3alu_core u_core (
        .i_cmd       (t_cmd'(r_cmd)),
        .i_dest      (r_dest),
        .i_src       (r_src),
        .i_shift_imm (r_imm),
        .o_result    (n_res)
    );

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.result_low  = r_res[HALF_W-1:0];
    assign o_rsp.result_high = r_res[VEC_W-1:HALF_W];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_vld && !r_out_vld))
        else $error("Registers not empty after reset.");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_rsp.ready) |-> !i_req.ready)
        else $error("Input accepted while both registers hold an item.");

    a_item_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_adv) |=> r_out_vld)
        else $error("Item lost between input and result registers.");

    a_no_duplicate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_rsp.ready && !r_in_vld) |=> !r_out_vld)
        else $error("Result repeated after it was taken.");

endmodule

// File: tb/sv/tb_ssse3_packed_integer_alu_top.sv
module tb_ssse3_packed_integer_alu_top
    import ssse3alu_pkg::*;
();

    localparam int VEC_BYTES   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;
    localparam int PAUSE_PCT   = 33;

    typedef struct {
        t_cmd         op;
        logic [127:0] value;
    } t_alu_expect;

    logic i_clk;
    logic i_rst_n;

    ssse3alu_in_if  req_if();
    ssse3alu_out_if rsp_if();

    ssse3_packed_integer_alu_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_alu_expect expected_results[$];
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          op_count[16];
    int          cycle_count     = 0;
    bit          src_pause_en    = 1'b1;
    bit          sink_pause_en   = 1'b1;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    // Element i of w bytes, sign-extended.
    function automatic longint lane_sx(input logic [127:0] v, input int w, input int i);
        longint x;
        int     k;
        x = 0;
        for (k = w - 1; k >= 0; k--) begin
            x = (x << 8) | longint'(v[8*(i*w+k) +: 8]);
        end
        if (x[8*w-1]) begin
            x = x - (longint'(1) << (8*w));
        end
        return x;
    endfunction

    function automatic logic [127:0] lane_set(input logic [127:0] v, input int w,
                                              input int i, input longint x);
        int k;
        for (k = 0; k < w; k++) begin
            v[8*(i*w+k) +: 8] = x[8*k +: 8];
        end
        return v;
    endfunction

    function automatic longint clamp_word(input longint x);
        longint r;
        if (x > 32767) begin
            r = 32767;
        end else if (x < -32768) begin
            r = -32768;
        end else begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic [127:0] alu_result(input t_cmd op, input logic [127:0] d,
                                                input logic [127:0] s, input logic [7:0] imm);
        logic [127:0] r;
        logic [127:0] v;
        logic [255:0] span;
        logic [31:0]  u;
        logic [7:0]   c;
        longint       a;
        longint       b;
        longint       t;
        int           w;
        int           i;
        int           h;
        int           half;
        bit           sub;
        bit           sat;
        r = '0;
        case (op)
            CMD_ABS_B, CMD_ABS_W, CMD_ABS_D: begin
                w = 1 << int'(op);
                for (i = 0; i < VEC_BYTES / w; i++) begin
                    a = lane_sx(s, w, i);
                    r = lane_set(r, w, i, (a < 0) ? -a : a);
                end
            end
            CMD_ALIGN: begin
                if (imm <= ALIGN_MAX) begin
                    span = {d, s} >> (8 * int'(imm));
                    r = span[127:0];
                end
            end
            CMD_HADD_W, CMD_HADD_D, CMD_HADDS_W, CMD_HSUB_W, CMD_HSUB_D, CMD_HSUBS_W: begin
                w    = (op == CMD_HADD_D || op == CMD_HSUB_D) ? 4 : 2;
                sub  = (op == CMD_HSUB_W || op == CMD_HSUB_D || op == CMD_HSUBS_W);
                sat  = (op == CMD_HADDS_W || op == CMD_HSUBS_W);
                half = VEC_BYTES / w / 2;
                for (h = 0; h < 2; h++) begin
                    v = h ? s : d;
                    for (i = 0; i < half; i++) begin
                        a = lane_sx(v, w, 2*i);
                        b = lane_sx(v, w, 2*i + 1);
                        t = sub ? a - b : a + b;
                        if (sat) begin
                            t = clamp_word(t);
                        end
                        r = lane_set(r, w, h*half + i, t);
                    end
                end
            end
            CMD_MADDUBS: begin
                for (i = 0; i < 8; i++) begin
                    t = longint'(d[16*i +: 8]) * lane_sx(s, 1, 2*i)
                      + longint'(d[16*i+8 +: 8]) * lane_sx(s, 1, 2*i + 1);
                    r = lane_set(r, 2, i, clamp_word(t));
                end
            end
            CMD_MULHRS: begin
                for (i = 0; i < 8; i++) begin
                    t = lane_sx(d, 2, i) * lane_sx(s, 2, i);
                    u = t[31:0];
                    u = ((u >> 14) + 32'd1) >> 1;
                    r[16*i +: 16] = u[15:0];
                end
            end
            CMD_SHUFFLE: begin
                for (i = 0; i < VEC_BYTES; i++) begin
                    c = s[8*i +: 8];
                    r[8*i +: 8] = c[7] ? 8'h00 : d[8*c[3:0] +: 8];
                end
            end
            CMD_SIGN_B, CMD_SIGN_W, CMD_SIGN_D: begin
                w = 1 << (int'(op) - int'(CMD_SIGN_B));
                for (i = 0; i < VEC_BYTES / w; i++) begin
                    a = lane_sx(s, w, i);
                    b = lane_sx(d, w, i);
                    t = (a < 0) ? -b : ((a == 0) ? 0 : b);
                    r = lane_set(r, w, i, t);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Holds valid high until the item is taken; the caller never lowers it in the
    // same step, so the next item can follow at once.
    task automatic send_op(input t_cmd op, input logic [127:0] d, input logic [127:0] s,
                           input logic [7:0] imm);
        t_alu_expect e;
        while (src_pause_en && $urandom_range(99) < PAUSE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= op;
        req_if.dest_low  <= d[63:0];
        req_if.dest_high <= d[127:64];
        req_if.src_low   <= s[63:0];
        req_if.src_high  <= s[127:64];
        req_if.shift_imm <= imm;
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
        e.op    = op;
        e.value = alu_result(op, d, s, imm);
        expected_results.push_back(e);
        items_sent++;
        op_count[int'(op)]++;
    endtask

    always @(posedge i_clk) begin
        t_alu_expect e;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item arrived with nothing outstanding");
            end else begin
                e = expected_results.pop_front();
                if (rsp_if.result_low !== e.value[63:0]) begin
                    report_mismatch($sformatf("%s result_low got %h want %h",
                        e.op.name(), rsp_if.result_low, e.value[63:0]));
                end
                if (rsp_if.result_high !== e.value[127:64]) begin
                    report_mismatch($sformatf("%s result_high got %h want %h",
                        e.op.name(), rsp_if.result_high, e.value[127:64]));
                end
                results_checked++;
            end
        end
        rsp_if.ready <= (sink_pause_en && $urandom_range(99) < PAUSE_PCT) ? 1'b0 : 1'b1;
    end

    function automatic logic [127:0] rand_vec();
        logic [127:0] v;
        int           k;
        case ($urandom_range(3))
            0, 1: v = {$urandom, $urandom, $urandom, $urandom};
            2: begin
                for (k = 0; k < 16; k++) begin
                    case ($urandom_range(5))
                        0: v[8*k +: 8] = 8'h00;
                        1: v[8*k +: 8] = 8'h7f;
                        2: v[8*k +: 8] = 8'h80;
                        3: v[8*k +: 8] = 8'hff;
                        4: v[8*k +: 8] = 8'h01;
                        default: v[8*k +: 8] = 8'($urandom);
                    endcase
                end
            end
            default: begin
                for (k = 0; k < 8; k++) begin
                    case ($urandom_range(5))
                        0: v[16*k +: 16] = 16'h0000;
                        1: v[16*k +: 16] = 16'h7fff;
                        2: v[16*k +: 16] = 16'h8000;
                        3: v[16*k +: 16] = 16'hffff;
                        4: v[16*k +: 16] = 16'h0001;
                        default: v[16*k +: 16] = 16'($urandom);
                    endcase
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rand_imm();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
    endfunction

    task automatic test_abs_extremes();
        logic [127:0] s;
        s = 128'h80000000_7fffffff_8000ffff_7f80ff01;
        send_op(CMD_ABS_B, '1, s, 8'h00);
        send_op(CMD_ABS_W, '0, s, 8'hff);
        send_op(CMD_ABS_D, 128'h5a, s, 8'h00);
    endtask

    task automatic test_align_counts();
        logic [127:0] d;
        logic [127:0] s;
        d = 128'h1f1e1d1c_1b1a1918_17161514_13121110;
        s = 128'h0f0e0d0c_0b0a0908_07060504_03020100;
        send_op(CMD_ALIGN, d, s, 8'd0);
        send_op(CMD_ALIGN, d, s, 8'd15);
        send_op(CMD_ALIGN, d, s, 8'd16);
        send_op(CMD_ALIGN, d, s, 8'd31);
        send_op(CMD_ALIGN, d, s, 8'd32);
        send_op(CMD_ALIGN, d, s, 8'd255);
    endtask

    task automatic test_horizontal_saturation();
        logic [127:0] d;
        logic [127:0] s;
        d = 128'h7fff7fff_80008000_80017fff_ffff0001;
        s = 128'h80007fff_00008000_7fffffff_12345678;
        send_op(CMD_HADD_W, d, s, 8'h00);
        send_op(CMD_HADD_D, d, s, 8'h00);
        send_op(CMD_HADDS_W, d, s, 8'h00);
        send_op(CMD_HSUB_W, d, s, 8'h00);
        send_op(CMD_HSUB_D, d, s, 8'h00);
        send_op(CMD_HSUBS_W, d, s, 8'h00);
    endtask

    task automatic test_multiply_corners();
        send_op(CMD_MADDUBS, '1, {16{8'h7f}}, 8'h00);
        send_op(CMD_MADDUBS, '1, {16{8'h80}}, 8'h00);
        send_op(CMD_MULHRS, 128'h8000_8000_7fff_7fff_0001_ffff_4000_c000,
                128'h8000_7fff_7fff_8000_0001_ffff_4000_4000, 8'h00);
    endtask

    task automatic test_shuffle_zeroing();
        logic [127:0] d;
        d = 128'hafaeadac_abaaa9a8_a7a6a5a4_a3a2a1a0;
        send_op(CMD_SHUFFLE, d, 128'h80ff0f00_8f7f1001_70f0030c_85050a1e, 8'h00);
        send_op(CMD_SHUFFLE, d, 128'h00010203_04050607_08090a0b_0c0d0e0f, 8'h00);
    endtask

    task automatic test_sign_apply();
        logic [127:0] d;
        logic [127:0] s;
        d = 128'h80000000_7fffffff_12345678_80000000;
        s = 128'h80000000_00000000_00000001_ffffffff;
        send_op(CMD_SIGN_B, d, s, 8'h00);
        send_op(CMD_SIGN_W, d, s, 8'h00);
        send_op(CMD_SIGN_D, d, s, 8'h00);
    endtask

    task automatic test_random_mix(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_op(t_cmd'($urandom_range(15)), rand_vec(), rand_vec(), rand_imm());
        end
    endtask

    task automatic test_back_to_back(input int count);
        src_pause_en  = 1'b0;
        sink_pause_en = 1'b0;
        test_random_mix(count);
        src_pause_en  = 1'b1;
        sink_pause_en = 1'b1;
    endtask

    initial begin
        int k;
        int ops_seen;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_ABS_B;
        req_if.dest_low  = '0;
        req_if.dest_high = '0;
        req_if.src_low   = '0;
        req_if.src_high  = '0;
        req_if.shift_imm = '0;
        rsp_if.ready     = 1'b0;
        for (k = 0; k < 16; k++) begin
            op_count[k] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_abs_extremes();
        test_align_counts();
        test_horizontal_saturation();
        test_multiply_corners();
        test_shuffle_zeroing();
        test_sign_apply();
        test_random_mix(400);
        test_back_to_back(150);
        test_random_mix(200);

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        ops_seen = 0;
        for (k = 0; k < 16; k++) begin
            if (op_count[k] != 0) begin
                ops_seen++;
            end
        end
        $display("Sent %0d items covering %0d of 16 operations, checked %0d results.",
                 items_sent, ops_seen, results_checked);
        $display("Stimulus mixed lane extremes, align counts around the limit and random stalls.");
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
